// ===== rtl/wbpc_pkg.sv =====
// Shared constants, types and character helpers for the phrase classifier.
`default_nettype none
package wbpc_pkg;

  localparam int WIN_DEPTH  = 35;
  localparam int RULE_COUNT = 5;

  // Phrases right-justified: the last character sits in bits [7:0], so the
  // character expected in window cell i is bits [8*i +: 8].
  localparam logic [WIN_DEPTH*8-1:0] PHRASE_TAB [RULE_COUNT] = '{
    "load trigger not triggered",
    "check filament at trigger",
    "did not trigger hub sensor",
    "post extruder gear toolhead sensor",
    "pre extruder gear toolhead sensor"
  };

  localparam int PHRASE_LEN [RULE_COUNT] = '{26, 25, 26, 34, 33};

  typedef enum logic [1:0] {
    SEG_SPOOL    = 2'd0,
    SEG_HUB      = 2'd1,
    SEG_TOOLHEAD = 2'd2,
    SEG_OUTPUT   = 2'd3
  } segment_t;

  localparam segment_t SEG_TAB [RULE_COUNT] = '{
    SEG_SPOOL, SEG_SPOOL, SEG_HUB, SEG_TOOLHEAD, SEG_OUTPUT
  };

  typedef logic [RULE_COUNT-1:0][7:0] exp_chars_t;

  typedef struct packed {
    logic [RULE_COUNT-1:0] match_cur;
    logic [RULE_COUNT-1:0] match_nxt;
    logic                  word_cur;
    logic                  word_nxt;
  } cell_stat_t;

  function automatic logic [7:0] fold_lower(input logic [7:0] c);
    if (c >= 8'h41 && c <= 8'h5A) begin
      return c + 8'd32;
    end
    return c;
  endfunction

  function automatic logic is_word(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h30 && c <= 8'h39);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/wbpc_in_if.sv =====
// Input channel: one message byte per word with an end-of-message flag.
`default_nettype none
interface wbpc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       last_byte;

  modport source (output valid, output msg_byte, output last_byte, input ready);
  modport sink   (input valid, input msg_byte, input last_byte, output ready);
endinterface
`default_nettype wire

// ===== rtl/wbpc_out_if.sv =====
// Result channel: classification of one message per word.
`default_nettype none
interface wbpc_out_if;
  logic       valid;
  logic       ready;
  logic       recognized;
  logic [1:0] segment;

  modport source (output valid, output recognized, output segment, input ready);
  modport sink   (input valid, input recognized, input segment, output ready);
endinterface
`default_nettype wire

// ===== rtl/wbpc_cell.sv =====
// One window cell: holds a folded character and compares it against the rules.
`default_nettype none
module wbpc_cell (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                shift,
  input  wire logic                clear,
  input  wire logic [7:0]          char_in,
  input  wire logic                valid_in,
  input  wire wbpc_pkg::exp_chars_t exp_char,
  output logic [7:0]               char_out,
  output logic                     valid_out,
  output wbpc_pkg::cell_stat_t     stat
);
  import wbpc_pkg::*;

  logic [7:0] char_r, char_nxt;
  logic       valid_r, valid_nxt;

  always_comb begin
    char_nxt  = shift ? char_in : char_r;
    valid_nxt = valid_r;
    if (clear) begin
      valid_nxt = 1'b0;
    end else if (shift) begin
      valid_nxt = valid_in;
    end
  end

  always_ff @(posedge clk) begin
    char_r <= char_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Compare both the held character and the one about to shift in, so the
  // end of a message can be judged on the window as it will be.
  always_comb begin
    for (int r = 0; r < RULE_COUNT; r++) begin
      stat.match_cur[r] = (char_r == exp_char[r]);
      stat.match_nxt[r] = (char_in == exp_char[r]);
    end
    stat.word_cur = is_word(char_r);
    stat.word_nxt = is_word(char_in);
  end

  assign char_out  = char_r;
  assign valid_out = valid_r;

endmodule
`default_nettype wire

// ===== rtl/word_bounded_phrase_classifier.sv =====
// Streaming classifier: spots five fixed phrases on word boundaries in a message.
//
// in_ch carries one message byte per word, last_byte marking the final byte;
// out_ch carries one word per message: recognized and the segment of the
// first matching rule in table order (0 when nothing matched).
// Matching is case-insensitive for ASCII letters; a phrase counts only when
// the characters on both sides are non-word characters or message ends.
// Throughput: one byte per cycle while out_ch is not stalled, messages back to back
// with no gap. Latency: the result word is valid in the cycle after the last byte
// is accepted. The window is a row of 35 cells shifting one byte per cycle while
// bytes are accepted; the phrase compares and boundary tests run in parallel on it.
// A single output register holds the result; in_ch.ready stays high while
// that register is empty or being drained, so any byte is held while a
// result word waits on a stalled out_ch.
// Reset (rst_n low, synchronous) empties the window, clears the match
// flags and drops any pending result. No clearing pass is needed.
`default_nettype none
module word_bounded_phrase_classifier (
  input  wire logic  clk,
  input  wire logic  rst_n,
  wbpc_in_if.sink    in_ch,
  wbpc_out_if.source out_ch
);
  import wbpc_pkg::*;

  logic                  accept;
  logic                  last_acc;
  logic [7:0]            head_char;
  logic [7:0]            char_q [WIN_DEPTH];
  logic                  valid_q [WIN_DEPTH];
  logic                  vin [WIN_DEPTH];
  cell_stat_t            stat [WIN_DEPTH];
  exp_chars_t            exp_c [WIN_DEPTH];
  logic [RULE_COUNT-1:0][WIN_DEPTH-1:0] mc_col, mn_col;
  logic [RULE_COUNT-1:0] ends_cur, ends_nxt;
  logic [RULE_COUNT-1:0] hits_r, hits_nxt, hits_base, hits_final;
  logic                  out_valid_r, out_valid_nxt;
  logic                  rec_r, rec_nxt;
  segment_t              seg_r, seg_nxt;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign last_acc    = accept && in_ch.last_byte;
  assign head_char   = fold_lower(in_ch.msg_byte);

  for (genvar i = 0; i < WIN_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      assign vin[i] = 1'b1;
      wbpc_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift    (accept),
        .clear    (last_acc),
        .char_in  (head_char),
        .valid_in (1'b1),
        .exp_char (exp_c[i]),
        .char_out (char_q[i]),
        .valid_out(valid_q[i]),
        .stat     (stat[i])
      );
    end else begin : g_body
      assign vin[i] = valid_q[i-1];
      wbpc_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift    (accept),
        .clear    (last_acc),
        .char_in  (char_q[i-1]),
        .valid_in (valid_q[i-1]),
        .exp_char (exp_c[i]),
        .char_out (char_q[i]),
        .valid_out(valid_q[i]),
        .stat     (stat[i])
      );
    end
    for (genvar r = 0; r < RULE_COUNT; r++) begin : g_exp
      assign exp_c[i][r]  = (i < PHRASE_LEN[r]) ? PHRASE_TAB[r][8*i +: 8] : 8'h00;
      assign mc_col[r][i] = stat[i].match_cur[r];
      assign mn_col[r][i] = stat[i].match_nxt[r];
    end
  end

  // Per rule: all phrase cells match, the window holds enough bytes, and the
  // cell just past the phrase is empty or a non-word character.
  for (genvar r = 0; r < RULE_COUNT; r++) begin : g_rule
    localparam int L = PHRASE_LEN[r];
    localparam logic [WIN_DEPTH-1:0] MASK = {WIN_DEPTH{1'b1}} >> (WIN_DEPTH - L);
    assign ends_cur[r] = (&(mc_col[r] | ~MASK)) && valid_q[L-1] &&
                         (!valid_q[L] || !stat[L].word_cur);
    assign ends_nxt[r] = (&(mn_col[r] | ~MASK)) && vin[L-1] &&
                         (!vin[L] || !stat[L].word_nxt);
  end

  always_comb begin
    // The incoming byte is the right neighbor of phrases ending in cell 0.
    hits_base  = hits_r | (stat[0].word_nxt ? '0 : ends_cur);
    hits_final = hits_base | ends_nxt;
    rec_nxt    = rec_r;
    seg_nxt    = seg_r;
    hits_nxt   = hits_r;
    if (accept) begin
      hits_nxt = in_ch.last_byte ? '0 : hits_base;
    end
    if (last_acc) begin
      rec_nxt = 1'b0;
      seg_nxt = SEG_SPOOL;
      for (int r = RULE_COUNT - 1; r >= 0; r--) begin
        if (hits_final[r]) begin
          rec_nxt = 1'b1;
          seg_nxt = SEG_TAB[r];
        end
      end
    end
    out_valid_nxt = out_valid_r;
    if (last_acc) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hits_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      hits_r      <= hits_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
    seg_r <= seg_nxt;
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.recognized = rec_r;
  assign out_ch.segment    = seg_r;

endmodule
`default_nettype wire

// ===== rtl/wbpc_checker.sv =====
// Port-level checks for the phrase classifier, bound to the top level.
`default_nettype none
module wbpc_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       in_last,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       recognized,
  input wire logic [1:0] segment
);
  import wbpc_pkg::*;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word present after reset");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_last |=> out_valid)
    else $error("no result word after last byte");

  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_last))
    else $error("result word without a last byte");

  a_unrec_segment: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !recognized |-> segment == SEG_SPOOL)
    else $error("segment set on unrecognized message");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(recognized) && $stable(segment))
    else $error("stalled result word changed");

endmodule

bind word_bounded_phrase_classifier wbpc_checker u_wbpc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_last   (in_ch.last_byte),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .recognized(out_ch.recognized),
  .segment   (out_ch.segment)
);
`default_nettype wire
